[src/oarp_pkg.sv]
// Shared types and constants for the roll-axis obstacle avoidance controller.
package oarp_pkg;

    localparam int DIST_W      = 10;
    localparam int FADE_BITS   = 12;
    localparam int TRIG_BITS   = 14;
    localparam int ROLL_LIMIT  = 4500;
    localparam int DIV5_RECIP  = 52429;
    localparam int DIV5_SHIFT  = 18;

    localparam logic [FADE_BITS:0] FADE_ONE = {1'b1, {FADE_BITS{1'b0}}};

    localparam logic [2:0] REG_KP_GAIN        = 3'd0;
    localparam logic [2:0] REG_KI_GAIN        = 3'd1;
    localparam logic [2:0] REG_DISTANCE_LIMIT = 3'd2;
    localparam logic [2:0] REG_APPROACH_SCALE = 3'd3;
    localparam logic [2:0] REG_INNER_FENCE    = 3'd4;
    localparam logic [2:0] REG_OUTER_FENCE    = 3'd5;

    typedef struct packed {
        logic              start;
        logic [DIST_W-1:0] obs_dist;
        logic [DIST_W-1:0] inner;
        logic [DIST_W-1:0] outer;
    } fade_req_t;

    typedef struct packed {
        logic               done;
        logic [FADE_BITS:0] fade;
    } fade_sts_t;

endpackage

[src/obstacle_avoid_roll_pi.sv]
// Top level of the roll-axis obstacle avoidance PI controller.
// Each control tick is one input word and gives one output word. The block takes a new word
// only when idle, so ticks are handled one at a time: a tick taken while not flying goes
// straight to the result, a flying tick where the loop stays idle ends after the divide by
// five, and a tick where the PI loop runs waits at the pilot fade product, when the distance
// lies between the fences, until the twelve-step fade divider is done. All products are formed
// one at a time on one 18 by 18 multiplier. The next word is accepted in the cycle after a
// result is handed to the output register, even while that result still waits to be taken;
// a finished result that finds the output register still full holds the block until that word is taken.
module obstacle_avoid_roll_pi
#(
    parameter int FRACTION_BITS = 12
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [12:0] velocity_north,
    input  logic signed [12:0] velocity_east,
    input  logic signed [15:0] cos_heading,
    input  logic signed [15:0] sin_heading,
    input  logic [9:0]         obstacle_distance,
    input  logic signed [13:0] pilot_roll,
    input  logic               flying,
    input  logic               restart,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [13:0] roll_command,
    output logic               avoiding
);
    import oarp_pkg::*;

    localparam int PF_W  = 27 + FRACTION_BITS;
    localparam int SUM_W = ((PF_W > 48) ? PF_W : 48) + 1;
    localparam int SHIFT = FRACTION_BITS + FADE_BITS;

    localparam logic signed [SUM_W-1:0] SUM_HI   = SUM_W'(ROLL_LIMIT);
    localparam logic signed [SUM_W-1:0] SUM_LO   = -SUM_HI;
    localparam logic signed [13:0]      ROLL_HI  = 14'(ROLL_LIMIT);
    localparam logic signed [13:0]      ROLL_LO  = -ROLL_HI;
    localparam logic signed [35:0]      INT_MAX  = 36'sh07FFFFFFF;
    localparam logic signed [35:0]      INT_MIN  = -36'sh080000000;

    typedef enum logic [3:0] {
        S_IDLE, S_VE_C, S_VN_S, S_TGT, S_DIV5, S_ERR, S_KP, S_KI,
        S_INT, S_PI, S_PF, S_SUM, S_CLAMP, S_DONE
    } state_t;

    state_t state_reg;

    logic [15:0] kp_reg;
    logic [15:0] ki_reg;
    logic [9:0]  limit_reg;
    logic [5:0]  scale_reg;
    logic [9:0]  inner_reg;
    logic [9:0]  outer_reg;

    logic signed [12:0] vn_reg;
    logic signed [12:0] ve_reg;
    logic signed [15:0] cos_reg;
    logic signed [15:0] sin_reg;
    logic [9:0]         dist_reg;
    logic signed [13:0] pilot_reg;

    logic signed [35:0]      prod_reg;
    logic signed [28:0]      vec_reg;
    logic signed [15:0]      rv_reg;
    logic signed [16:0]      target_reg;
    logic                    near_limit_reg;
    logic signed [17:0]      err_reg;
    logic signed [34:0]      p_reg;
    logic signed [31:0]      integral_reg;
    logic signed [35:0]      pi_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [13:0]      res_roll_reg;
    logic                    res_avoid_reg;
    logic                    out_valid_reg;
    logic signed [13:0]      roll_command_reg;
    logic                    avoiding_reg;

    logic signed [17:0]      mul_a;
    logic signed [17:0]      mul_b;
    logic signed [10:0]      dist_diff;
    logic signed [29:0]      vel_diff;
    logic signed [18:0]      rv_times5;
    logic signed [18:0]      target_ext;
    logic                    near_limit;
    logic                    too_fast;
    logic signed [16:0]      used;
    logic signed [17:0]      err_next;
    logic signed [35:0]      int_sum;
    logic signed [31:0]      int_sat;
    logic signed [35:0]      pi_next;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [SUM_W-1:0] sum_shifted;
    logic signed [13:0]      sum_clamped;
    logic signed [13:0]      pilot_clamped;
    fade_req_t               fade_req;
    fade_sts_t               fade_sts;

    oarp_fade u_fade
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fade_req),
        .sts   (fade_sts)
    );

    assign fade_req.start    = in_valid && in_ready && flying;
    assign fade_req.obs_dist = obstacle_distance;
    assign fade_req.inner    = inner_reg;
    assign fade_req.outer    = outer_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg    <= 16'd24576;
            ki_reg    <= 16'd82;
            limit_reg <= 10'd100;
            scale_reg <= 6'd10;
            inner_reg <= 10'd110;
            outer_reg <= 10'd130;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KP_GAIN:        kp_reg    <= cfg_data;
                REG_KI_GAIN:        ki_reg    <= cfg_data;
                REG_DISTANCE_LIMIT: limit_reg <= cfg_data[9:0];
                REG_APPROACH_SCALE: scale_reg <= cfg_data[5:0];
                REG_INNER_FENCE:    inner_reg <= cfg_data[9:0];
                REG_OUTER_FENCE:    outer_reg <= cfg_data[9:0];
                default:            ;
            endcase
        end
    end

    assign dist_diff = $signed({1'b0, dist_reg}) - $signed({1'b0, limit_reg});

    always_comb
    begin
        case (state_reg)
            S_VE_C:
            begin
                mul_a = 18'(ve_reg);
                mul_b = 18'(cos_reg);
            end
            S_VN_S:
            begin
                mul_a = 18'(vn_reg);
                mul_b = 18'(sin_reg);
            end
            S_TGT:
            begin
                mul_a = $signed({12'd0, scale_reg});
                mul_b = 18'(dist_diff);
            end
            S_DIV5:
            begin
                mul_a = $signed({1'b0, prod_reg[16:0]});
                mul_b = 18'(DIV5_RECIP);
            end
            S_KP:
            begin
                mul_a = $signed({2'b0, kp_reg});
                mul_b = err_reg;
            end
            S_KI:
            begin
                mul_a = $signed({2'b0, ki_reg});
                mul_b = err_reg;
            end
            S_PF:
            begin
                mul_a = 18'(pilot_reg);
                mul_b = $signed({5'd0, fade_sts.fade});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign vel_diff    = 30'(vec_reg) - 30'($signed(prod_reg[28:0]));
    assign rv_times5   = (19'(rv_reg) <<< 2) + 19'(rv_reg);
    assign target_ext  = 19'($signed(prod_reg[16:0]));
    assign near_limit  = dist_reg < limit_reg;
    assign too_fast    = rv_times5 > target_ext;
    assign used        = near_limit_reg ? target_reg
                                        : $signed({1'b0, prod_reg[DIV5_SHIFT+15:DIV5_SHIFT]});
    assign err_next    = 18'(used) - 18'(rv_reg);
    assign int_sum     = 36'(integral_reg) + prod_reg;
    assign int_sat     = (int_sum > INT_MAX) ? INT_MAX[31:0] :
                         (int_sum < INT_MIN) ? INT_MIN[31:0] : int_sum[31:0];
    assign pi_next     = 36'(p_reg) + 36'(integral_reg);
    assign sum_next    = (SUM_W'($signed(prod_reg[26:0])) <<< FRACTION_BITS)
                       + (SUM_W'(pi_reg) <<< FADE_BITS);
    assign sum_shifted = sum_reg >>> SHIFT;
    assign sum_clamped = (sum_shifted > SUM_HI) ? ROLL_HI :
                         (sum_shifted < SUM_LO) ? ROLL_LO : sum_shifted[13:0];
    assign pilot_clamped = (pilot_reg > ROLL_HI) ? ROLL_HI :
                           (pilot_reg < ROLL_LO) ? ROLL_LO : pilot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            integral_reg  <= '0;
        end
        else
        begin
            prod_reg <= mul_a * mul_b;
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        vn_reg    <= velocity_north;
                        ve_reg    <= velocity_east;
                        cos_reg   <= cos_heading;
                        sin_reg   <= sin_heading;
                        dist_reg  <= obstacle_distance;
                        pilot_reg <= pilot_roll;
                        if (restart)
                        begin
                            integral_reg <= '0;
                        end
                        if (flying)
                        begin
                            state_reg <= S_VE_C;
                        end
                        else
                        begin
                            res_roll_reg  <= pilot_roll;
                            res_avoid_reg <= 1'b0;
                            state_reg     <= S_DONE;
                        end
                    end
                end
                S_VE_C:
                begin
                    state_reg <= S_VN_S;
                end
                S_VN_S:
                begin
                    vec_reg   <= prod_reg[28:0];
                    state_reg <= S_TGT;
                end
                S_TGT:
                begin
                    rv_reg    <= vel_diff[29:TRIG_BITS];
                    state_reg <= S_DIV5;
                end
                S_DIV5:
                begin
                    target_reg     <= prod_reg[16:0];
                    near_limit_reg <= near_limit;
                    if (near_limit || too_fast)
                    begin
                        state_reg <= S_ERR;
                    end
                    else
                    begin
                        integral_reg  <= '0;
                        res_roll_reg  <= pilot_clamped;
                        res_avoid_reg <= 1'b0;
                        state_reg     <= S_DONE;
                    end
                end
                S_ERR:
                begin
                    err_reg   <= err_next;
                    state_reg <= S_KP;
                end
                S_KP:
                begin
                    state_reg <= S_KI;
                end
                S_KI:
                begin
                    p_reg     <= prod_reg[34:0];
                    state_reg <= S_INT;
                end
                S_INT:
                begin
                    integral_reg <= int_sat;
                    state_reg    <= S_PI;
                end
                S_PI:
                begin
                    pi_reg    <= pi_next;
                    state_reg <= S_PF;
                end
                S_PF:
                begin
                    if (fade_sts.done)
                    begin
                        state_reg <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    sum_reg   <= sum_next;
                    state_reg <= S_CLAMP;
                end
                S_CLAMP:
                begin
                    res_roll_reg  <= sum_clamped;
                    res_avoid_reg <= 1'b1;
                    state_reg     <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        roll_command_reg <= res_roll_reg;
                        avoiding_reg     <= res_avoid_reg;
                        out_valid_reg    <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign roll_command = roll_command_reg;
    assign avoiding     = avoiding_reg;

`ifndef SYNTHESIS
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && restart) |=> (integral_reg == '0))
        else $error("Integrator not cleared after a restart word.");

    a_avoid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && avoiding) |-> (roll_command <= ROLL_HI && roll_command >= ROLL_LO))
        else $error("Avoidance roll command outside the roll limit.");

    a_fade_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fade_sts.done |-> (fade_sts.fade <= FADE_ONE))
        else $error("Fade factor above unity.");
`endif

endmodule

[src/oarp_fade.sv]
// Fade factor unit: a bit-serial restoring divider that forms the pilot roll fade.
module oarp_fade
(
    input  logic                clk,
    input  logic                rst_n,
    input  oarp_pkg::fade_req_t req,
    output oarp_pkg::fade_sts_t sts
);
    import oarp_pkg::*;

    localparam int CNT_W = $clog2(FADE_BITS + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [DIST_W-1:0]   rem_reg;
    logic [DIST_W-1:0]   den_reg;
    logic [FADE_BITS:0]  quot_reg;
    logic [DIST_W:0]     rem_dbl;
    logic                rem_ge;
    logic [DIST_W:0]     rem_sub;

    assign rem_dbl = {rem_reg, 1'b0};
    assign rem_ge  = rem_dbl >= {1'b0, den_reg};
    assign rem_sub = rem_ge ? (rem_dbl - {1'b0, den_reg}) : rem_dbl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            if (req.obs_dist >= req.outer)
            begin
                quot_reg <= FADE_ONE;
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else if (req.obs_dist < req.inner)
            begin
                quot_reg <= '0;
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                rem_reg  <= req.obs_dist - req.inner;
                den_reg  <= req.outer - req.inner;
                quot_reg <= '0;
                cnt_reg  <= CNT_W'(FADE_BITS);
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
            end
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_sub[DIST_W-1:0];
            quot_reg <= {quot_reg[FADE_BITS-1:0], rem_ge};
            cnt_reg  <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign sts.done = done_reg;
    assign sts.fade = quot_reg;

endmodule
